// File: rtl/core/vmt_pkg.sv
// shared constants and helpers for the vector move-towards pipeline
`default_nettype none

package vmt_pkg;

    localparam int POS_WIDTH_DEF = 32;
    localparam int DIR_FRAC_DEF  = 14;
    localparam int AXES          = 3;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/vector_move_towards_top.sv
// top level of the vector move-towards pipeline
//
//  port group   direction  payload
//  in  beat     sink       src_x/y/z, dst_x/y/z, step_len
//  out beat     source     new_x/y/z, finished, dir_valid, dir_x/y/z
//
// one beat enters per cycle unless the output stalls; the square root and divider
// resolve one bit per stage; every stage advances together when the output register
// is empty or being taken, so a stall freezes the whole pipe and no beat is lost or
// repeated
// reset clears only the valid bits
`default_nettype none

module vector_move_towards_top #(
    parameter int POS_WIDTH     = vmt_pkg::POS_WIDTH_DEF,
    parameter int DIR_FRAC_BITS = vmt_pkg::DIR_FRAC_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [POS_WIDTH-1:0]   src_x,
    input  logic signed [POS_WIDTH-1:0]   src_y,
    input  logic signed [POS_WIDTH-1:0]   src_z,
    input  logic signed [POS_WIDTH-1:0]   dst_x,
    input  logic signed [POS_WIDTH-1:0]   dst_y,
    input  logic signed [POS_WIDTH-1:0]   dst_z,
    input  logic        [POS_WIDTH-2:0]   step_len,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [POS_WIDTH-1:0]   new_x,
    output logic signed [POS_WIDTH-1:0]   new_y,
    output logic signed [POS_WIDTH-1:0]   new_z,
    output logic                          finished,
    output logic                          dir_valid,
    output logic signed [DIR_FRAC_BITS+1:0] dir_x,
    output logic signed [DIR_FRAC_BITS+1:0] dir_y,
    output logic signed [DIR_FRAC_BITS+1:0] dir_z
);
    import vmt_pkg::*;

    localparam int W   = POS_WIDTH;
    localparam int F   = DIR_FRAC_BITS;
    localparam int DW  = W + 1;
    localparam int L   = max_int(W, F + 1);
    localparam int DRW = F + 2;
    localparam int H   = (W + 1) / 2;
    localparam int NW  = max_int(2 * W - 1, W + F);
    localparam int SW0 = 7 * W - 1;
    localparam int SW1 = SW0 + 3 * W + 3;
    localparam int SW2 = 6 * W + 5;
    localparam int LN  = 2 * AXES;

    logic en;

    // front end
    logic [W-1:0]    src_in [AXES];
    logic [W-1:0]    dst_in [AXES];
    logic [SW0-1:0]  side0;
    logic            fr_valid;
    logic [W-1:0]    fr_mag [AXES];
    logic            fr_neg [AXES];
    logic [2*W+1:0]  fr_sum;
    logic [SW0-1:0]  fr_side;

    // square root
    logic [SW1-1:0]  side1;
    logic            sq_valid;
    logic [DW-1:0]   sq_root;
    logic [SW1-1:0]  sq_side;
    logic            u_neg [AXES];
    logic [W-1:0]    u_mag [AXES];
    logic [W-1:0]    u_src [AXES];
    logic [W-1:0]    u_dst [AXES];
    logic [W-2:0]    u_step;

    // product stages
    logic            p1_valid_reg;
    logic [H+W-2:0]  p_lo_reg [AXES];
    logic [2*W-H-2:0] p_hi_reg [AXES];
    logic [DW-1:0]   p1_dist_reg;
    logic            p1_fin_reg;
    logic            p1_dv_reg;
    logic [W-1:0]    p1_src_reg [AXES];
    logic [W-1:0]    p1_dst_reg [AXES];
    logic            p1_neg_reg [AXES];
    logic [W-1:0]    p1_mag_reg [AXES];
    logic            p2_valid_reg;
    logic [NW-1:0]   num_reg [LN];
    logic [DW-1:0]   p2_dist_reg;
    logic [SW2-1:0]  side2_reg;

    // divider and output
    logic            dv_valid;
    logic [L-1:0]    quo [LN];
    logic [SW2-1:0]  dv_side;
    logic            v_dv;
    logic            v_fin;
    logic            v_neg [AXES];
    logic [W-1:0]    v_src [AXES];
    logic [W-1:0]    v_dst [AXES];
    logic [W-1:0]    qp_c  [AXES];
    logic [DRW-1:0]  qd_c  [AXES];
    logic [W-1:0]    new_c [AXES];
    logic [DRW-1:0]  dir_c [AXES];

    logic            out_valid_reg;
    logic [W-1:0]    new_reg [AXES];
    logic            fin_reg;
    logic            dv_reg;
    logic [DRW-1:0]  dir_reg [AXES];

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    assign src_in[0] = src_x;
    assign src_in[1] = src_y;
    assign src_in[2] = src_z;
    assign dst_in[0] = dst_x;
    assign dst_in[1] = dst_y;
    assign dst_in[2] = dst_z;
    assign side0     = {src_x, src_y, src_z, dst_x, dst_y, dst_z, step_len};

    vmt_front #(
        .W  (W),
        .SW (SW0)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .src       (src_in),
        .dst       (dst_in),
        .in_side   (side0),
        .out_valid (fr_valid),
        .mag       (fr_mag),
        .neg       (fr_neg),
        .sumsq     (fr_sum),
        .out_side  (fr_side)
    );

    assign side1 = {fr_side, fr_mag[0], fr_mag[1], fr_mag[2], fr_neg[0], fr_neg[1], fr_neg[2]};

    vmt_sqrt #(
        .RW (DW),
        .SW (SW1)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .rad       (fr_sum),
        .in_side   (side1),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    always_comb
    begin
        u_step = sq_side[3 + 3*W +: W-1];
        for (int k = 0; k < AXES; k++)
        begin
            u_neg[k] = sq_side[2 - k];
            u_mag[k] = sq_side[3 + (2 - k) * W +: W];
            u_dst[k] = sq_side[3 + 4*W - 1 + (2 - k) * W +: W];
            u_src[k] = sq_side[3 + 7*W - 1 + (2 - k) * W +: W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg  <= sq_valid;
            p2_valid_reg  <= p1_valid_reg;
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_dist_reg <= sq_root;
            p1_fin_reg  <= sq_root <= DW'(u_step);
            p1_dv_reg   <= sq_root != '0;
            for (int k = 0; k < AXES; k++)
            begin
                // offset times step, split on the offset
                p_lo_reg[k]   <= u_mag[k][H-1:0] * u_step;
                p_hi_reg[k]   <= u_mag[k][W-1:H] * u_step;
                p1_src_reg[k] <= u_src[k];
                p1_dst_reg[k] <= u_dst[k];
                p1_neg_reg[k] <= u_neg[k];
                p1_mag_reg[k] <= u_mag[k];
                num_reg[k]        <= (NW'(p_hi_reg[k]) << H) + NW'(p_lo_reg[k]);
                num_reg[AXES + k] <= NW'(p1_mag_reg[k]) << F;
            end
            p2_dist_reg <= p1_dist_reg;
            side2_reg   <= {p1_src_reg[0], p1_src_reg[1], p1_src_reg[2],
                            p1_dst_reg[0], p1_dst_reg[1], p1_dst_reg[2],
                            p1_neg_reg[0], p1_neg_reg[1], p1_neg_reg[2],
                            p1_fin_reg, p1_dv_reg};
        end
    end

    vmt_div #(
        .NW    (NW),
        .DW    (DW),
        .QW    (L),
        .LANES (LN),
        .SW    (SW2)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p2_valid_reg),
        .num       (num_reg),
        .den       (p2_dist_reg),
        .in_side   (side2_reg),
        .out_valid (dv_valid),
        .quo       (quo),
        .out_side  (dv_side)
    );

    always_comb
    begin
        v_dv  = dv_side[0];
        v_fin = dv_side[1];
        for (int k = 0; k < AXES; k++)
        begin
            v_neg[k] = dv_side[2 + (2 - k)];
            v_dst[k] = dv_side[5 + (2 - k) * W +: W];
            v_src[k] = dv_side[5 + 3*W + (2 - k) * W +: W];
            qp_c[k]  = quo[k][W-1:0];
            qd_c[k]  = DRW'(quo[AXES + k]);
            new_c[k] = v_fin ? v_dst[k] : v_src[k] + (v_neg[k] ? (~qp_c[k] + 1'b1) : qp_c[k]);
            dir_c[k] = v_dv ? (v_neg[k] ? (~qd_c[k] + 1'b1) : qd_c[k]) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_reg <= v_fin;
            dv_reg  <= v_dv;
            for (int k = 0; k < AXES; k++)
            begin
                new_reg[k] <= new_c[k];
                dir_reg[k] <= dir_c[k];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign new_x     = new_reg[0];
    assign new_y     = new_reg[1];
    assign new_z     = new_reg[2];
    assign finished  = fin_reg;
    assign dir_valid = dv_reg;
    assign dir_x     = dir_reg[0];
    assign dir_y     = dir_reg[1];
    assign dir_z     = dir_reg[2];

endmodule

`default_nettype wire

// File: rtl/core/vmt_front.sv
// front end: per-axis offset, magnitude and squared length, four register stages
`default_nettype none

module vmt_front #(
    parameter int W  = vmt_pkg::POS_WIDTH_DEF,
    parameter int SW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [W-1:0]  src [vmt_pkg::AXES],
    input  logic [W-1:0]  dst [vmt_pkg::AXES],
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [W-1:0]  mag [vmt_pkg::AXES],
    output logic          neg [vmt_pkg::AXES],
    output logic [2*W+1:0] sumsq,
    output logic [SW-1:0] out_side
);
    import vmt_pkg::*;

    localparam int H   = (W + 1) / 2;
    localparam int HW  = W - H;
    localparam int NST = 4;

    logic [NST-1:0]  v_reg;
    logic [W-1:0]    m_reg [NST][AXES];
    logic            n_reg [NST][AXES];
    logic [SW-1:0]   s_reg [NST];
    logic [2*HW-1:0] hh_reg [AXES];
    logic [W-1:0]    hl_reg [AXES];
    logic [2*H-1:0]  ll_reg [AXES];
    logic [2*W-1:0]  sq_reg [AXES];
    logic [2*W+1:0]  sum_reg;

    logic [W:0] off_c [AXES];
    logic [W:0] abs_c [AXES];

    always_comb
    begin
        for (int k = 0; k < AXES; k++)
        begin
            off_c[k] = {dst[k][W-1], dst[k]} - {src[k][W-1], src[k]};
            abs_c[k] = off_c[k][W] ? (~off_c[k] + 1'b1) : off_c[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg[0] <= in_side;
            for (int i = 1; i < NST; i++)
            begin
                s_reg[i] <= s_reg[i-1];
            end
            for (int k = 0; k < AXES; k++)
            begin
                m_reg[0][k] <= abs_c[k][W-1:0];
                n_reg[0][k] <= off_c[k][W];
                for (int i = 1; i < NST; i++)
                begin
                    m_reg[i][k] <= m_reg[i-1][k];
                    n_reg[i][k] <= n_reg[i-1][k];
                end
                // square split into half-width partial products
                hh_reg[k] <= m_reg[0][k][W-1:H] * m_reg[0][k][W-1:H];
                hl_reg[k] <= m_reg[0][k][W-1:H] * m_reg[0][k][H-1:0];
                ll_reg[k] <= m_reg[0][k][H-1:0] * m_reg[0][k][H-1:0];
                sq_reg[k] <= {hh_reg[k], {(2*H){1'b0}}}
                           + ((2*W)'(hl_reg[k]) << (H + 1))
                           + (2*W)'(ll_reg[k]);
            end
            sum_reg <= (2*W+2)'(sq_reg[0]) + (2*W+2)'(sq_reg[1]) + (2*W+2)'(sq_reg[2]);
        end
    end

    assign out_valid = v_reg[NST-1];
    assign sumsq     = sum_reg;
    assign out_side  = s_reg[NST-1];

    always_comb
    begin
        for (int k = 0; k < AXES; k++)
        begin
            mag[k] = m_reg[NST-1][k];
            neg[k] = n_reg[NST-1][k];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/vmt_sqrt.sv
// pipelined integer square root, one root bit per register stage
`default_nettype none

module vmt_sqrt #(
    parameter int RW = 33,
    parameter int SW = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [2*RW-1:0] rad,
    input  logic [SW-1:0]   in_side,
    output logic            out_valid,
    output logic [RW-1:0]   root,
    output logic [SW-1:0]   out_side
);

    logic [RW-1:0]   v_reg;
    logic [RW:0]     rem_reg [RW];
    logic [RW-1:0]   rt_reg  [RW];
    logic [2*RW-1:0] rad_reg [RW];
    logic [SW-1:0]   s_reg   [RW];

    logic [RW:0]     rem_i   [RW];
    logic [RW-1:0]   rt_i    [RW];
    logic [2*RW-1:0] rad_i   [RW];
    logic [RW+2:0]   cur_c   [RW];
    logic [RW+2:0]   trial_c [RW];
    logic            ge_c    [RW];

    always_comb
    begin
        for (int i = 0; i < RW; i++)
        begin
            if (i == 0)
            begin
                rem_i[i] = '0;
                rt_i[i]  = '0;
                rad_i[i] = rad;
            end
            else
            begin
                rem_i[i] = rem_reg[i-1];
                rt_i[i]  = rt_reg[i-1];
                rad_i[i] = rad_reg[i-1];
            end
            // bring down the next two radicand bits, try root*4+1
            cur_c[i]   = {rem_i[i], rad_i[i][2*RW-1 -: 2]};
            trial_c[i] = {1'b0, rt_i[i], 2'b01};
            ge_c[i]    = cur_c[i] >= trial_c[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[RW-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < RW; i++)
            begin
                rem_reg[i] <= ge_c[i] ? (RW+1)'(cur_c[i] - trial_c[i]) : cur_c[i][RW:0];
                rt_reg[i]  <= {rt_i[i][RW-2:0], ge_c[i]};
                rad_reg[i] <= rad_i[i] << 2;
                s_reg[i]   <= (i == 0) ? in_side : s_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    assign out_valid = v_reg[RW-1];
    assign root      = rt_reg[RW-1];
    assign out_side  = s_reg[RW-1];

endmodule

`default_nettype wire

// File: rtl/core/vmt_div.sv
// pipelined restoring divider, several numerators over one shared divisor
`default_nettype none

module vmt_div #(
    parameter int NW    = 63,
    parameter int DW    = 33,
    parameter int QW    = 32,
    parameter int LANES = 6,
    parameter int SW    = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num [LANES],
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW-1:0] quo [LANES],
    output logic [SW-1:0] out_side
);

    logic [QW-1:0] v_reg;
    logic [DW-1:0] rem_reg [QW][LANES];
    logic [QW-1:0] lo_reg  [QW][LANES];
    logic [QW-1:0] q_reg   [QW][LANES];
    logic [DW-1:0] d_reg   [QW];
    logic [SW-1:0] s_reg   [QW];

    logic [DW-1:0] rem_i [QW][LANES];
    logic [QW-1:0] lo_i  [QW][LANES];
    logic [QW-1:0] q_i   [QW][LANES];
    logic [DW-1:0] d_i   [QW];
    logic [DW:0]   cur_c [QW][LANES];
    logic [DW:0]   dif_c [QW][LANES];
    logic          ge_c  [QW][LANES];

    always_comb
    begin
        for (int i = 0; i < QW; i++)
        begin
            d_i[i] = (i == 0) ? den : d_reg[(i == 0) ? 0 : i-1];
            for (int l = 0; l < LANES; l++)
            begin
                if (i == 0)
                begin
                    // upper numerator part stays below the divisor
                    rem_i[i][l] = DW'(num[l] >> QW);
                    lo_i[i][l]  = num[l][QW-1:0];
                    q_i[i][l]   = '0;
                end
                else
                begin
                    rem_i[i][l] = rem_reg[i-1][l];
                    lo_i[i][l]  = lo_reg[i-1][l];
                    q_i[i][l]   = q_reg[i-1][l];
                end
                cur_c[i][l] = {rem_i[i][l], lo_i[i][l][QW-1]};
                dif_c[i][l] = cur_c[i][l] - {1'b0, d_i[i]};
                ge_c[i][l]  = cur_c[i][l] >= {1'b0, d_i[i]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[QW-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < QW; i++)
            begin
                d_reg[i] <= d_i[i];
                s_reg[i] <= (i == 0) ? in_side : s_reg[(i == 0) ? 0 : i-1];
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[i][l] <= ge_c[i][l] ? dif_c[i][l][DW-1:0] : cur_c[i][l][DW-1:0];
                    lo_reg[i][l]  <= lo_i[i][l] << 1;
                    q_reg[i][l]   <= {q_i[i][l][QW-2:0], ge_c[i][l]};
                end
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign out_side  = s_reg[QW-1];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            quo[l] = q_reg[QW-1][l];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/vmt_checker.sv
// port-level checks for the vector move-towards top, bound to it
`default_nettype none

module vmt_checker #(
    parameter int POS_WIDTH     = vmt_pkg::POS_WIDTH_DEF,
    parameter int DIR_FRAC_BITS = vmt_pkg::DIR_FRAC_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [POS_WIDTH-1:0]   new_x,
    input logic                          finished,
    input logic                          dir_valid,
    input logic signed [DIR_FRAC_BITS+1:0] dir_x,
    input logic signed [DIR_FRAC_BITS+1:0] dir_y,
    input logic signed [DIR_FRAC_BITS+1:0] dir_z
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(new_x) && $stable(finished))
        else $error("stalled result beat changed");

    // the pipe only takes a beat when it can move
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow pipe advance");

    // zero length means reached with a zero direction
    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !dir_valid |-> finished && dir_x == 0 && dir_y == 0 && dir_z == 0)
        else $error("zero length result malformed");

    // a partial move needs a nonzero length
    a_move_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !finished |-> dir_valid)
        else $error("partial move without direction");

endmodule

bind vector_move_towards_top vmt_checker #(
    .POS_WIDTH     (POS_WIDTH),
    .DIR_FRAC_BITS (DIR_FRAC_BITS)
) u_vmt_checker (.*);

`default_nettype wire

// File: verif/vector_move_towards_top_test.sv
// testbench for the vector move-towards pipeline: directed table then random beats
`default_nettype none

module vector_move_towards_top_test;

    localparam int PW  = vmt_pkg::POS_WIDTH_DEF;
    localparam int DW  = vmt_pkg::DIR_FRAC_DEF + 2;
    localparam int LATENCY = PW + vmt_pkg::max_int(PW, DW - 1) + 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_RANDOM = 1430;

    typedef struct packed {
        logic signed [PW-1:0] sx, sy, sz, dx, dy, dz;
        logic [PW-2:0] step;
    } move_req_t;

    typedef struct packed {
        logic signed [PW-1:0] nx, ny, nz;
        logic fin, dval;
        logic signed [DW-1:0] ux, uy, uz;
    } move_res_t;

    typedef struct packed {
        move_req_t req;
        logic known;
        move_res_t res;
    } table_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [PW-1:0] src_x = '0, src_y = '0, src_z = '0;
    logic signed [PW-1:0] dst_x = '0, dst_y = '0, dst_z = '0;
    logic [PW-2:0] step_len = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [PW-1:0] new_x, new_y, new_z;
    logic finished, dir_valid;
    logic signed [DW-1:0] dir_x, dir_y, dir_z;

    move_res_t pending_moves[$];
    int errors = 0;
    int idle_cycles = 0;
    int sink_wait = 0;
    table_row_t rows[$];

    vector_move_towards_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .src_x(src_x), .src_y(src_y), .src_z(src_z),
        .dst_x(dst_x), .dst_y(dst_y), .dst_z(dst_z),
        .step_len(step_len),
        .out_valid(out_valid), .out_ready(out_ready),
        .new_x(new_x), .new_y(new_y), .new_z(new_z),
        .finished(finished), .dir_valid(dir_valid),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // truncated integer square root of a 128-bit sum of squares
    function automatic logic [63:0] isqrt128(input logic [127:0] s);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= s)
                r = c;
        end
        return r;
    endfunction

    // off * mul / len, truncated toward zero
    function automatic logic signed [63:0] scaled_offset(input logic signed [63:0] off,
                                                         input logic [63:0] mul,
                                                         input logic [63:0] len);
        logic [127:0] mag;
        logic [127:0] q;
        mag = off < 0 ? -off : off;
        q = (mag * {64'd0, mul}) / {64'd0, len};
        return off < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    function automatic move_res_t predict_move(input move_req_t r);
        move_res_t res;
        logic signed [63:0] s[3], d[3], o[3], np, dv;
        logic [127:0] sumsq;
        logic [63:0] len, a;
        s[0] = r.sx; s[1] = r.sy; s[2] = r.sz;
        d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
        sumsq = '0;
        for (int k = 0; k < 3; k++)
        begin
            o[k] = d[k] - s[k];
            a = o[k] < 0 ? -o[k] : o[k];
            sumsq += {64'd0, a} * {64'd0, a};
        end
        len = isqrt128(sumsq);
        res.fin = len <= {33'd0, r.step};
        res.dval = len != 0;
        for (int k = 0; k < 3; k++)
        begin
            np = res.fin ? d[k] : s[k] + scaled_offset(o[k], {33'd0, r.step}, len);
            dv = res.dval ? scaled_offset(o[k], 64'd1 << (DW - 2), len) : 0;
            case (k)
                0: begin res.nx = np[PW-1:0]; res.ux = dv[DW-1:0]; end
                1: begin res.ny = np[PW-1:0]; res.uy = dv[DW-1:0]; end
                default: begin res.nz = np[PW-1:0]; res.uz = dv[DW-1:0]; end
            endcase
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    function automatic logic [PW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
            1: return $signed($urandom_range(0, 2000)) - 1000;
            2: return $urandom;
            default: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic move_req_t rand_move();
        move_req_t r;
        r.sx = rand_coord(); r.sy = rand_coord(); r.sz = rand_coord();
        case ($urandom_range(0, 3))
            0: begin r.dx = r.sx; r.dy = r.sy; r.dz = r.sz; end
            1: begin
                r.dx = r.sx + $signed($urandom_range(0, 8)) - 4;
                r.dy = r.sy + $signed($urandom_range(0, 8)) - 4;
                r.dz = r.sz;
            end
            default: begin r.dx = rand_coord(); r.dy = rand_coord(); r.dz = rand_coord(); end
        endcase
        case ($urandom_range(0, 4))
            0: r.step = '0;
            1: r.step = {(PW-1){1'b1}};
            2: r.step = (PW-1)'($urandom_range(0, 32'h0004_0000));
            default: r.step = (PW-1)'($urandom);
        endcase
        return r;
    endfunction

    // valid stays up across back-to-back beats; it drops only for a gap
    task automatic send_move(input move_req_t r);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        {src_x, src_y, src_z, dst_x, dst_y, dst_z, step_len} <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function automatic table_row_t mk(input move_req_t r, input bit known,
                                      input move_res_t res);
        table_row_t t;
        t.req = r; t.known = known; t.res = res;
        return t;
    endfunction

    // sink: per-beat stall draw, check against expected queue
    always @(posedge clk)
    begin
        move_res_t want;
        int w;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_moves.size() == 0)
                    report_mismatch("unexpected beat", 0, 0);
                else
                begin
                    want = pending_moves.pop_front();
                    if (new_x !== want.nx) report_mismatch("new_x", new_x, want.nx);
                    if (new_y !== want.ny) report_mismatch("new_y", new_y, want.ny);
                    if (new_z !== want.nz) report_mismatch("new_z", new_z, want.nz);
                    if (finished !== want.fin) report_mismatch("finished", finished, want.fin);
                    if (dir_valid !== want.dval)
                        report_mismatch("dir_valid", dir_valid, want.dval);
                    if (dir_x !== want.ux) report_mismatch("dir_x", dir_x, want.ux);
                    if (dir_y !== want.uy) report_mismatch("dir_y", dir_y, want.uy);
                    if (dir_z !== want.uz) report_mismatch("dir_z", dir_z, want.uz);
                end
                w = $urandom_range(0, 19);
                sink_wait <= w;
                out_ready <= (w == 0);
            end
            else if (sink_wait > 0)
            begin
                sink_wait <= sink_wait - 1;
                out_ready <= (sink_wait == 1);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // record expectation at accept time
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            pending_moves.push_back(predict_move({src_x, src_y, src_z, dst_x, dst_y, dst_z,
                                                  step_len}));
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("vector_move_towards_top_test: FAIL");
            $finish;
        end
    end

    initial
    begin
        localparam logic signed [PW-1:0] MAXP = {1'b0, {(PW-1){1'b1}}};
        localparam logic signed [PW-1:0] MINP = {1'b1, {(PW-1){1'b0}}};
        localparam logic [PW-2:0] MAXS = {(PW-1){1'b1}};
        localparam logic signed [DW-1:0] ONE = 1 <<< (DW - 2);
        move_res_t res;
        move_req_t r;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero length: target returned, direction invalid
        rows.push_back(mk({MINP, MAXP, 32'sd5, MINP, MAXP, 32'sd5, 31'd0}, 1,
                          {MINP, MAXP, 32'sd5, 1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0}));
        rows.push_back(mk({96'd0, 96'd0, MAXS}, 1, {96'd0, 1'b1, 1'b0, 48'd0}));
        // reached with nonzero length, exact axis distance
        rows.push_back(mk({32'sd0, 32'sd0, 32'sd0, 32'sd100, 32'sd0, 32'sd0, 31'd100}, 1,
                          {32'sd100, 32'sd0, 32'sd0, 1'b1, 1'b1, ONE, 16'sd0, 16'sd0}));
        rows.push_back(mk({32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, -32'sd64, MAXS}, 1,
                          {32'sd0, 32'sd0, -32'sd64, 1'b1, 1'b1, 16'sd0, 16'sd0, -ONE}));
        // moving along one axis, step zero
        rows.push_back(mk({32'sd7, 32'sd0, 32'sd0, 32'sd7, 32'sd1000, 32'sd0, 31'd0}, 1,
                          {32'sd7, 32'sd0, 32'sd0, 1'b0, 1'b1, 16'sd0, ONE, 16'sd0}));
        // full span extremes, then small and mixed offsets
        rows.push_back(mk({MINP, MINP, MINP, MAXP, MAXP, MAXP, 31'd0}, 0, '0));
        rows.push_back(mk({MAXP, MAXP, MAXP, MINP, MINP, MINP, MAXS}, 0, '0));
        rows.push_back(mk({MAXP, MINP, MAXP, MINP, MAXP, MINP, 31'h4000_0000}, 0, '0));
        rows.push_back(mk({MINP, 32'sd0, MAXP, MAXP, 32'sd0, MINP, 31'h0001_0000}, 0, '0));
        rows.push_back(mk({32'sd0, 32'sd0, 32'sd0, 32'sd3, 32'sd4, 32'sd0, 31'd4}, 0, '0));
        rows.push_back(mk({32'sd0, 32'sd0, 32'sd0, -32'sd3, -32'sd4, 32'sd12, 31'd12}, 0, '0));
        rows.push_back(mk({32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd1, 32'sd1, 31'd1}, 0, '0));
        rows.push_back(mk({32'h1234_5678, 32'h8765_4321, 32'h0f0f_0f0f,
                           32'hf0f0_f0f0, 32'h5555_5555, 32'haaaa_aaaa, 31'h2aaa_aaaa}, 0, '0));

        fork
            begin
                foreach (rows[i])
                begin
                    if (rows[i].known)
                    begin
                        res = predict_move(rows[i].req);
                        if (res !== rows[i].res)
                            report_mismatch("table row prediction", i, 0);
                    end
                    send_move(rows[i].req);
                end
                for (int n = 0; n < N_RANDOM; n++)
                begin
                    if (n == N_RANDOM / 2)
                    begin
                        // hold off until the pipe has drained
                        in_valid <= 1'b0;
                        @(posedge clk);
                        while (pending_moves.size() != 0)
                            @(posedge clk);
                    end
                    r = rand_move();
                    send_move(r);
                end
                in_valid <= 1'b0;
            end
        join
        while (pending_moves.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (errors == 0)
            $display("vector_move_towards_top_test: PASS");
        else
            $display("vector_move_towards_top_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
